/* hdl/sgxy_pkg.sv */
// sgxy_pkg: constants, types and helper functions for the 2-d smoother
// shared by the store, control, math and top modules of the block; no dependencies
package sgxy_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // dimension and position widths
  localparam int unsigned MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DIM_RAW   = $clog2(MAX_DIM + 1);
  localparam int unsigned DIM_W     = (DIM_RAW > 11) ? DIM_RAW : 11;
  localparam int unsigned CNT_RAW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned CNT_W     = (CNT_RAW > DIM_W + 2) ? CNT_RAW : DIM_W + 2;
  localparam int unsigned CFG_W     = 11;

  // row store: 7 row banks x 7 column banks, column c lives at address c/7
  localparam int unsigned NBANK     = 7;
  localparam int unsigned BANK_D    = (MAX_WIDTH + 6) / 7;
  localparam int unsigned AW        = $clog2(BANK_D);
  localparam int unsigned PIX_W     = 8;

  // divide by 7 through a reciprocal
  localparam int unsigned M7_S      = DIM_W + 3;
  localparam logic [M7_S-1:0] M7_M  = M7_S'((2 ** M7_S + 6) / 7);

  // final scaling: floor((s*256 + 21) / 42), biased to stay positive
  localparam int unsigned N_W       = 22;
  localparam int unsigned DIV_MW    = 28;
  localparam int unsigned DIV_S     = 33;
  localparam logic [DIV_MW-1:0] DIV_M = 28'd204522253;
  localparam logic [N_W-1:0] RND_BIAS = 22'd688149;
  localparam int unsigned Q_W       = 17;
  localparam logic [17:0] Q_OFFSET  = 18'd16384;

  // apb register map
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  // write and read requests to the banked store
  typedef struct packed {
    logic                         we;
    logic [2:0]                   wrow;
    logic [2:0]                   wcol;
    logic [AW-1:0]                waddr;
    logic [PIX_W-1:0]             wdata;
    logic                         re;
    logic [2:0]                   rm;
    logic [NBANK-1:0][AW-1:0]     raddr_row;
    logic [AW-1:0]                raddr_col;
  } mem_req_t;

  // everything the datapath needs about one result
  typedef struct packed {
    logic                         valid;
    logic [2:0]                   rm;
    logic [2:0]                   cm;
    logic [NBANK-1:0][2:0]        rsel;
    logic [NBANK-1:0][2:0]        csel;
    logic                         byp;
    logic [PIX_W-1:0]             gray;
    logic [9:0]                   col;
    logic [9:0]                   row;
    logic                         last;
  } tap_t;

  typedef logic [NBANK-1:0][NBANK-1:0][PIX_W-1:0] bank_data_t;

  // wrap a small signed value into 0..6
  function automatic logic [2:0] wrap7(input logic signed [4:0] v);
    logic signed [4:0] r;
    r = v;
    if (v < 0) begin
      r = v + 5'sd7;
    end else if (v >= 5'sd7) begin
      r = v - 5'sd7;
    end
    return r[2:0];
  endfunction

  // x mod 7 through multiplication by the reciprocal
  function automatic logic [2:0] mod7(input logic [DIM_W-1:0] x);
    logic [DIM_W+M7_S-1:0] p;
    logic [DIM_W-1:0]      q;
    logic [DIM_W-1:0]      r;
    p = {{M7_S{1'b0}}, x} * {{DIM_W{1'b0}}, M7_M};
    q = p[M7_S +: DIM_W];
    r = x - ((q << 3) - q);
    return r[2:0];
  endfunction

endpackage

/* hdl/sgxy_if.sv */
// sgxy_if: valid/ready channel interfaces for pixels in and results out
// depends on nothing but the handshake convention
interface sgxy_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] gray;

  modport source (output valid, output command, output gray, input ready);
  modport sink   (input valid, input command, input gray, output ready);
endinterface

interface sgxy_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] filtered_value;
  logic [9:0]         out_column;
  logic [9:0]         out_row;
  logic               frame_end;

  modport source (output valid, output filtered_value, output out_column,
                  output out_row, output frame_end, input ready);
  modport sink   (input valid, input filtered_value, input out_column,
                  input out_row, input frame_end, output ready);
endinterface

/* hdl/sgxy_ram.sv */
// sgxy_ram: generic single-write, single-read ram with registered read
// no dependencies
module sgxy_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 147
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* hdl/sgxy_store.sv */
// sgxy_store: row store as 7x7 banks, one read per bank per cycle
// depends on sgxy_pkg and sgxy_ram
module sgxy_store
  import sgxy_pkg::*;
(
  input  logic       clk_i,
  input  mem_req_t   req_i,
  output bank_data_t rdata_o
);

  for (genvar i = 0; i < NBANK; i++) begin : g_row
    for (genvar j = 0; j < NBANK; j++) begin : g_col
      logic          we;
      logic [AW-1:0] raddr;

      // row bank of the result row serves the horizontal taps
      assign we    = req_i.we && (req_i.wrow == 3'(i)) && (req_i.wcol == 3'(j));
      assign raddr = (req_i.rm == 3'(i)) ? req_i.raddr_row[j] : req_i.raddr_col;

      sgxy_ram #(
        .WIDTH (PIX_W),
        .DEPTH (BANK_D)
      ) u_ram (
        .clk_i   (clk_i),
        .we_i    (we),
        .waddr_i (req_i.waddr),
        .wdata_i (req_i.wdata),
        .re_i    (req_i.re),
        .raddr_i (raddr),
        .rdata_o (rdata_o[i][j])
      );
    end
  end

endmodule

/* hdl/sgxy_ctrl.sv */
// sgxy_ctrl: frame counters, write position, result position and tap selection
// depends on sgxy_pkg
module sgxy_ctrl
  import sgxy_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  logic             en_i,
  input  logic             command_i,
  input  logic [PIX_W-1:0] gray_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] width_i,
  input  logic [CFG_W-1:0] height_i,
  output mem_req_t         req_o,
  output tap_t             tap_o
);

  logic [DIM_W-1:0] weff, heff, wlast, hlast;
  logic [2:0]       wlast_m7, hlast_m7;
  logic [CNT_W-1:0] total, tw3;
  logic [2*DIM_W-1:0] area;

  logic [CNT_W-1:0] prx_q, prx_d, rs_q, rs_d;
  logic [DIM_W-1:0] wcol_q, wcol_d, rcol_q, rcol_d, rrow_q, rrow_d;
  logic [2:0]       wcm_q, wcm_d, wrm_q, wrm_d, rcm_q, rcm_d, rrm_q, rrm_d;
  logic [AW-1:0]    wcq_q, wcq_d, rcq_q, rcq_d;

  logic wr, full, prod_pix, prod_drn, produce, done;

  // effective frame size and derived constants
  always_comb begin
    weff = (width_i == '0) ? DIM_W'(1) :
           ({{(DIM_W-CFG_W){1'b0}}, width_i} > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) :
           {{(DIM_W-CFG_W){1'b0}}, width_i};
    heff = (height_i == '0) ? DIM_W'(1) :
           ({{(DIM_W-CFG_W){1'b0}}, height_i} > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) :
           {{(DIM_W-CFG_W){1'b0}}, height_i};
    wlast    = weff - DIM_W'(1);
    hlast    = heff - DIM_W'(1);
    wlast_m7 = mod7(wlast);
    hlast_m7 = mod7(hlast);
    area     = weff * heff;
    total    = CNT_W'(area);
    tw3      = CNT_W'({2'b00, weff, 1'b0}) + CNT_W'(weff);
  end

  // transaction classification
  always_comb begin
    full     = prx_q >= total;
    wr       = acc_i && (command_i == CMD_PIXEL) && !full;
    prod_pix = wr && (prx_q >= tw3) && (rs_q < total);
    prod_drn = acc_i && (command_i == CMD_DRAIN) && full && (rs_q < total);
    produce  = prod_pix || prod_drn;
    done     = prod_drn && (rs_q + CNT_W'(1) == total);
  end

  // counter and position updates
  always_comb begin
    prx_d  = prx_q;  rs_d   = rs_q;
    wcol_d = wcol_q; wcm_d  = wcm_q; wcq_d = wcq_q; wrm_d = wrm_q;
    rcol_d = rcol_q; rcm_d  = rcm_q; rcq_d = rcq_q;
    rrow_d = rrow_q; rrm_d  = rrm_q;
    if (wr) begin
      prx_d = prx_q + CNT_W'(1);
      if (wcol_q == wlast) begin
        wcol_d = '0; wcm_d = '0; wcq_d = '0;
        wrm_d  = (wrm_q == 3'd6) ? 3'd0 : wrm_q + 3'd1;
      end else begin
        wcol_d = wcol_q + DIM_W'(1);
        if (wcm_q == 3'd6) begin
          wcm_d = '0; wcq_d = wcq_q + AW'(1);
        end else begin
          wcm_d = wcm_q + 3'd1;
        end
      end
    end
    if (produce) begin
      rs_d = rs_q + CNT_W'(1);
      if (rcol_q == wlast) begin
        rcol_d = '0; rcm_d = '0; rcq_d = '0;
        rrow_d = rrow_q + DIM_W'(1);
        rrm_d  = (rrm_q == 3'd6) ? 3'd0 : rrm_q + 3'd1;
      end else begin
        rcol_d = rcol_q + DIM_W'(1);
        if (rcm_q == 3'd6) begin
          rcm_d = '0; rcq_d = rcq_q + AW'(1);
        end else begin
          rcm_d = rcm_q + 3'd1;
        end
      end
    end
    if (cfg_we_i || done) begin
      prx_d  = '0; rs_d  = '0;
      wcol_d = '0; wcm_d = '0; wcq_d = '0; wrm_d = '0;
      rcol_d = '0; rcm_d = '0; rcq_d = '0; rrow_d = '0; rrm_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prx_q  <= '0; rs_q  <= '0;
      wcol_q <= '0; wcm_q <= '0; wcq_q <= '0; wrm_q <= '0;
      rcol_q <= '0; rcm_q <= '0; rcq_q <= '0; rrow_q <= '0; rrm_q <= '0;
    end else begin
      prx_q  <= prx_d;  rs_q  <= rs_d;
      wcol_q <= wcol_d; wcm_q <= wcm_d; wcq_q <= wcq_d; wrm_q <= wrm_d;
      rcol_q <= rcol_d; rcm_q <= rcm_d; rcq_q <= rcq_d;
      rrow_q <= rrow_d; rrm_q <= rrm_d;
    end
  end

  // store requests: write the pixel, read the 13 taps of the next result
  always_comb begin
    logic signed [4:0] delta;
    logic signed [4:0] t;
    req_o.we        = wr;
    req_o.wrow      = wrm_q;
    req_o.wcol      = wcm_q;
    req_o.waddr     = wcq_q;
    req_o.wdata     = gray_i;
    req_o.re        = en_i;
    req_o.rm        = rrm_q;
    req_o.raddr_col = rcq_q;
    for (int j = 0; j < NBANK; j++) begin
      delta = signed'({2'b00, wrap7(signed'(5'(j) - 5'({2'b00, rcm_q}) + 5'd3))});
      t     = signed'(5'({2'b00, rcm_q})) + delta - 5'sd3;
      if (t < 0) begin
        req_o.raddr_row[j] = rcq_q - AW'(1);
      end else if (t >= 5'sd7) begin
        req_o.raddr_row[j] = rcq_q + AW'(1);
      end else begin
        req_o.raddr_row[j] = rcq_q;
      end
    end
  end

  // tap bank selection with clamping at the frame edges
  always_comb begin
    logic [DIM_W:0] cs, rsum;
    tap_o.valid = produce;
    tap_o.rm    = rrm_q;
    tap_o.cm    = rcm_q;
    tap_o.byp   = prod_pix;
    tap_o.gray  = gray_i;
    tap_o.col   = rcol_q[9:0];
    tap_o.row   = rrow_q[9:0];
    tap_o.last  = (rs_q == total - CNT_W'(1));
    for (int d = 0; d < NBANK; d++) begin
      cs   = {1'b0, rcol_q} + (DIM_W+1)'(d);
      rsum = {1'b0, rrow_q} + (DIM_W+1)'(d);
      if (cs < (DIM_W+1)'(3)) begin
        tap_o.rsel[d] = 3'd0;
      end else if (cs > {1'b0, weff} + (DIM_W+1)'(2)) begin
        tap_o.rsel[d] = wlast_m7;
      end else begin
        tap_o.rsel[d] = wrap7(signed'(5'({2'b00, rcm_q}) + 5'(d) - 5'd3));
      end
      if (rsum < (DIM_W+1)'(3)) begin
        tap_o.csel[d] = 3'd0;
      end else if (rsum > {1'b0, heff} + (DIM_W+1)'(2)) begin
        tap_o.csel[d] = hlast_m7;
      end else begin
        tap_o.csel[d] = wrap7(signed'(5'({2'b00, rrm_q}) + 5'(d) - 5'd3));
      end
    end
  end

endmodule

/* hdl/sgxy_math.sv */
// sgxy_math: weighted sums, divide by 42 and output register
// depends on sgxy_pkg
module sgxy_math
  import sgxy_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  tap_t               tap_i,
  input  bank_data_t         rdata_i,
  output logic               valid_o,
  output logic signed [17:0] value_o,
  output logic [9:0]         col_o,
  output logic [9:0]         row_o,
  output logic               last_o
);

  tap_t s1_q;
  logic s2_v_q, s3_v_q, out_v_q;
  logic [N_W-1:0] s2_n_q;
  logic [Q_W-1:0] s3_q_q;
  logic [9:0] s2_col_q, s2_row_q, s3_col_q, s3_row_q;
  logic s2_last_q, s3_last_q;
  logic signed [17:0] out_val_q;
  logic [9:0] out_col_q, out_row_q;
  logic out_last_q;

  logic [NBANK-1:0][PIX_W-1:0] rt, ct;
  logic signed [15:0] sx, sy, s;
  logic signed [N_W:0] n_s;
  logic [N_W+DIV_MW-1:0] prod;

  // tap values; the newest column tap comes from the input pixel on pixel transactions
  always_comb begin
    for (int d = 0; d < NBANK; d++) begin
      rt[d] = rdata_i[s1_q.rm][s1_q.rsel[d]];
      ct[d] = rdata_i[s1_q.csel[d]][s1_q.cm];
    end
    if (s1_q.byp) begin
      ct[NBANK-1] = s1_q.gray;
    end
  end

  // weights -2,3,6,7,6,3,-2 along row and column
  always_comb begin
    sx = 16'sd7 * signed'({8'd0, rt[3]})
       + 16'sd6 * signed'({8'd0, rt[2]} + {8'd0, rt[4]})
       + 16'sd3 * signed'({8'd0, rt[1]} + {8'd0, rt[5]})
       - 16'sd2 * signed'({8'd0, rt[0]} + {8'd0, rt[6]});
    sy = 16'sd7 * signed'({8'd0, ct[3]})
       + 16'sd6 * signed'({8'd0, ct[2]} + {8'd0, ct[4]})
       + 16'sd3 * signed'({8'd0, ct[1]} + {8'd0, ct[5]})
       - 16'sd2 * signed'({8'd0, ct[0]} + {8'd0, ct[6]});
    s   = sx + sy;
    n_s = (N_W+1)'(s) * (N_W+1)'(256) + signed'({1'b0, RND_BIAS});
    // reciprocal multiply works on the registered numerator
    prod = {{DIV_MW{1'b0}}, s2_n_q} * {{N_W{1'b0}}, DIV_M};
  end

  // pipeline, all stages advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q.valid <= 1'b0;
      s2_v_q     <= 1'b0;
      s3_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else if (en_i) begin
      s1_q       <= tap_i;
      s2_v_q     <= s1_q.valid;
      s3_v_q     <= s2_v_q;
      out_v_q    <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_n_q     <= n_s[N_W-1:0];
      s2_col_q   <= s1_q.col;
      s2_row_q   <= s1_q.row;
      s2_last_q  <= s1_q.last;
      s3_q_q     <= prod[DIV_S +: Q_W];
      s3_col_q   <= s2_col_q;
      s3_row_q   <= s2_row_q;
      s3_last_q  <= s2_last_q;
      out_val_q  <= signed'({1'b0, s3_q_q} - Q_OFFSET);
      out_col_q  <= s3_col_q;
      out_row_q  <= s3_row_q;
      out_last_q <= s3_last_q;
    end
  end

  assign valid_o = out_v_q;
  assign value_o = out_val_q;
  assign col_o   = out_col_q;
  assign row_o   = out_row_q;
  assign last_o  = out_last_q;

endmodule

/* hdl/savitzky_golay_xy_image_smoother.sv */
// channel   dir  payload                                         handshake
// in_i      in   command, gray                                   valid/ready
// out_o     out  filtered_value, out_column, out_row, frame_end  valid/ready
// apb       in   image_width @0x0, image_height @0x4             psel/penable
//
// one transaction per cycle in steady flow; a result is valid on out_o once its accepted
// transaction has passed the s1, s2, s3 and output registers of sgxy_math, and the
// banked row store gives all 13 taps in a single read
// reset clears counters and pipeline valids; the row store is not cleared
// a stalled output holds the whole pipeline and drops in_i.ready
//
// top level of the smoother; depends on sgxy_pkg, sgxy_if, sgxy_store,
// sgxy_ctrl and sgxy_math
module savitzky_golay_xy_image_smoother
  import sgxy_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sgxy_in_if.sink     in_i,
  sgxy_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFG_W-1:0] width_q, height_q;
  logic cfg_we, en, acc;
  mem_req_t   req;
  tap_t       tap;
  bank_data_t rdata;
  reg_idx_e   ridx;

  // configuration registers
  assign ridx   = reg_idx_e'(paddr[2]);
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1024);
      height_q <= CFG_W'(1024);
    end else if (cfg_we) begin
      unique case (ridx)
        REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        default:    width_q  <= width_q;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, width_q};
      REG_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, height_q};
      default:    prdata = '0;
    endcase
  end

  // global pipeline enable
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;
  assign acc        = in_i.valid && en;

  sgxy_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .en_i      (en),
    .command_i (in_i.command),
    .gray_i    (in_i.gray),
    .cfg_we_i  (cfg_we),
    .width_i   (width_q),
    .height_i  (height_q),
    .req_o     (req),
    .tap_o     (tap)
  );

  sgxy_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  sgxy_math u_math (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tap_i   (tap),
    .rdata_i (rdata),
    .valid_o (out_o.valid),
    .value_o (out_o.filtered_value),
    .col_o   (out_o.out_column),
    .row_o   (out_o.out_row),
    .last_o  (out_o.frame_end)
  );

endmodule
